>>> rtl/core/clp_pkg.sv
// Shared types and constants for the command line parser.
// Holds parser state codes, result event codes and the lexer step struct.
// No dependencies.
`default_nettype none

package clp_pkg;

   localparam int DATA_MAX_DEF = 32;
   localparam logic [5:0] DATA_LEN_RESET = 6'd32;
   localparam logic [6:0] CHAR_QUESTION = 7'h3F;

   localparam logic [2:0] EV_CONT = 3'd0;
   localparam logic [2:0] EV_ERR  = 3'd1;
   localparam logic [2:0] EV_MOVE = 3'd2;
   localparam logic [2:0] EV_QUIT = 3'd3;
   localparam logic [2:0] EV_EOF  = 3'd4;

   typedef enum logic [4:0] {
      ST_ERROR    = 5'd0,
      ST_LINE_ERR = 5'd1,
      ST_LINE     = 5'd2,
      ST_MV_M     = 5'd3,
      ST_MV_O     = 5'd4,
      ST_MV_V     = 5'd5,
      ST_MV_E     = 5'd6,
      ST_MV_SP    = 5'd7,
      ST_MV_DAT   = 5'd8,
      ST_MV_OK    = 5'd9,
      ST_QT_Q     = 5'd10,
      ST_QT_U     = 5'd11,
      ST_QT_I     = 5'd12,
      ST_QT_T     = 5'd13,
      ST_QT_SP    = 5'd14,
      ST_QT_DAT   = 5'd15,
      ST_QT_OK    = 5'd16
   } parse_state_type;

   typedef struct packed {
      parse_state_type nxt;
      logic            err;
      logic            cmd;
      logic [2:0]      cmd_ev;
      logic            dat;
      logic            fresh;
   } step_type;

endpackage

`default_nettype wire

>>> rtl/core/command_line_parser.sv
// Command line parser top level. Each accepted beat is registered in the idle
// state, then parsed, captured and its result formed in the execute state. A
// completed command then emits one result beat per captured character, read
// through the capture memory's registered read port. Reset is synchronous, needs
// no memory clearing pass, and leaves the parser at line start with the length at 32.
// Depends on clp_pkg and clp_lexer.
`default_nettype none

module command_line_parser #(
   parameter int DATA_MAX = clp_pkg::DATA_MAX_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [5:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_end_of_input,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_event_res,
   output logic [6:0] rsp_data_char,
   output logic       rsp_last
);
   import clp_pkg::*;

   localparam int CNT_W  = $clog2(DATA_MAX + 1);
   localparam int ADDR_W = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_EXEC,
      CTL_PUT,
      CTL_RD,
      CTL_LD
   } ctl_type;

   ctl_type         ctl_ff, ctl_in;
   parse_state_type parse_ff, parse_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [5:0]      dlen_ff, dlen_in;
   logic            eoi_ff, eoi_in;
   logic [6:0]      chr_ff, chr_in;
   logic [2:0]      pend_ev_ff, pend_ev_in;
   logic [2:0]      burst_ev_ff, burst_ev_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      rsp_ev_ff, rsp_ev_in;
   logic [6:0]      rsp_chr_ff, rsp_chr_in;
   logic            rsp_last_ff, rsp_last_in;

   logic [6:0]      mem [DATA_MAX];
   logic [6:0]      rdata_ff;
   logic            mem_we;
   logic            mem_re;
   logic [ADDR_W-1:0] mem_wa;

   step_type        step;
   logic            slot_free;
   logic            single_req;
   logic [2:0]      single_ev;
   logic [CNT_W-1:0] fill_base;
   logic [6:0]      dl7;
   logic [6:0]      eff7;
   logic [CNT_W-1:0] eff;
   logic            burst_last;

   clp_lexer u_lexer (
      .cur_state (parse_ff),
      .chr       (chr_ff),
      .step      (step)
   );

   assign req_stall     = (ctl_ff != CTL_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_ev_ff;
   assign rsp_data_char = rsp_chr_ff;
   assign rsp_last      = rsp_last_ff;
   assign slot_free     = !rsp_valid_ff || !rsp_stall;
   assign burst_last    = (CNT_W'(idx_ff + 1'b1) == fill_ff);

   always_comb begin
      dl7 = {1'b0, dlen_ff};
      if (dl7 == 7'd0) eff7 = 7'd1;
      else if (dl7 > 7'(DATA_MAX)) eff7 = 7'(DATA_MAX);
      else eff7 = dl7;
      eff = CNT_W'(eff7);
   end

   always_comb begin
      ctl_in       = ctl_ff;
      parse_in     = parse_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      dlen_in      = csr_wr_en ? csr_wr_data : dlen_ff;
      eoi_in       = eoi_ff;
      chr_in       = chr_ff;
      pend_ev_in   = pend_ev_ff;
      burst_ev_in  = burst_ev_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ev_in    = rsp_ev_ff;
      rsp_chr_in   = rsp_chr_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wa       = '0;
      single_req   = 1'b0;
      single_ev    = EV_CONT;
      fill_base    = step.fresh ? '0 : fill_ff;

      unique case (ctl_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               eoi_in = req_end_of_input;
               chr_in = req_char_code[7] ? CHAR_QUESTION : req_char_code[6:0];
               ctl_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            single_req = 1'b1;
            if (eoi_ff) begin
               single_ev = EV_EOF;
            end else begin
               parse_in = step.nxt;
               if (step.err) begin
                  single_ev = EV_ERR;
               end else if (step.cmd) begin
                  if (fill_ff == '0) begin
                     single_ev = step.cmd_ev;
                  end else begin
                     single_req  = 1'b0;
                     burst_ev_in = step.cmd_ev;
                     idx_in      = '0;
                     ctl_in      = CTL_RD;
                  end
               end else if (step.dat) begin
                  mem_we  = 1'b1;
                  mem_wa  = fill_base[ADDR_W-1:0];
                  fill_in = CNT_W'(fill_base + 1'b1);
                  if (fill_in >= eff) begin
                     parse_in = (step.nxt == ST_MV_DAT) ? ST_MV_OK : ST_QT_OK;
                  end
               end
            end
         end
         CTL_PUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_ev_in    = pend_ev_ff;
               rsp_chr_in   = '0;
               rsp_last_in  = 1'b1;
               ctl_in       = CTL_IDLE;
            end
         end
         CTL_RD: begin
            mem_re = 1'b1;
            ctl_in = CTL_LD;
         end
         CTL_LD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_ev_in    = burst_ev_ff;
               rsp_chr_in   = rdata_ff;
               rsp_last_in  = burst_last;
               idx_in       = CNT_W'(idx_ff + 1'b1);
               ctl_in       = burst_last ? CTL_IDLE : CTL_RD;
            end
         end
         default: ctl_in = CTL_IDLE;
      endcase

      if (single_req) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_ev_in    = single_ev;
            rsp_chr_in   = '0;
            rsp_last_in  = 1'b1;
            ctl_in       = CTL_IDLE;
         end else begin
            pend_ev_in = single_ev;
            ctl_in     = CTL_PUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_IDLE;
         parse_ff     <= ST_LINE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         dlen_ff      <= DATA_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         parse_ff     <= parse_in;
         fill_ff      <= fill_in;
         idx_ff       <= idx_in;
         dlen_ff      <= dlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      eoi_ff      <= eoi_in;
      chr_ff      <= chr_in;
      pend_ev_ff  <= pend_ev_in;
      burst_ev_ff <= burst_ev_in;
      rsp_ev_ff   <= rsp_ev_in;
      rsp_chr_ff  <= rsp_chr_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= chr_ff;
      end
      if (mem_re) begin
         rdata_ff <= mem[idx_ff[ADDR_W-1:0]];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/clp_lexer.sv
// Character classifier and next-state logic of the command line parser.
// Purely combinational; depends on clp_pkg.
`default_nettype none

module clp_lexer (
   input  clp_pkg::parse_state_type cur_state,
   input  logic [6:0]               chr,
   output clp_pkg::step_type        step
);
   import clp_pkg::*;

   localparam logic [6:0] CH_NL = 7'h0A;
   localparam logic [6:0] CH_SP = 7'h20;
   localparam logic [6:0] CH_M  = 7'h6D;
   localparam logic [6:0] CH_O  = 7'h6F;
   localparam logic [6:0] CH_V  = 7'h76;
   localparam logic [6:0] CH_E  = 7'h65;
   localparam logic [6:0] CH_Q  = 7'h71;
   localparam logic [6:0] CH_U  = 7'h75;
   localparam logic [6:0] CH_I  = 7'h69;
   localparam logic [6:0] CH_T  = 7'h74;
   localparam logic [6:0] GRAPH_LO = 7'd33;
   localparam logic [6:0] GRAPH_HI = 7'd126;

   logic [6:0]      lc;
   logic            is_sp;
   logic            is_graph;
   parse_state_type nxt;

   assign lc       = chr | CH_SP;
   assign is_sp    = (chr == CH_SP);
   assign is_graph = (chr >= GRAPH_LO) && (chr <= GRAPH_HI);

   always_comb begin
      step = '{nxt: ST_ERROR, err: 1'b0, cmd: 1'b0, cmd_ev: EV_CONT, dat: 1'b0, fresh: 1'b0};
      nxt  = ST_ERROR;
      if (chr == CH_NL) begin
         if (cur_state == ST_LINE || cur_state == ST_LINE_ERR ||
             cur_state == ST_MV_OK || cur_state == ST_QT_OK) begin
            nxt = ST_LINE;
            step.cmd    = (cur_state == ST_MV_OK) || (cur_state == ST_QT_OK);
            step.cmd_ev = (cur_state == ST_MV_OK) ? EV_MOVE : EV_QUIT;
         end else begin
            nxt = ST_LINE_ERR;
            step.err = 1'b1;
         end
      end else begin
         unique case (cur_state)
            ST_LINE, ST_LINE_ERR: begin
               if (is_sp) nxt = ST_LINE;
               else if (lc == CH_M) nxt = ST_MV_M;
               else if (lc == CH_Q) nxt = ST_QT_Q;
               else nxt = ST_ERROR;
            end
            ST_MV_M:   nxt = (lc == CH_O) ? ST_MV_O : ST_ERROR;
            ST_MV_O:   nxt = (lc == CH_V) ? ST_MV_V : ST_ERROR;
            ST_MV_V:   nxt = (lc == CH_E) ? ST_MV_E : ST_ERROR;
            ST_MV_E:   nxt = is_sp ? ST_MV_SP : ST_ERROR;
            ST_MV_SP: begin
               if (is_sp) nxt = ST_MV_SP;
               else nxt = is_graph ? ST_MV_DAT : ST_ERROR;
            end
            ST_MV_DAT: nxt = is_graph ? ST_MV_DAT : ST_ERROR;
            ST_MV_OK:  nxt = is_sp ? ST_MV_OK : ST_ERROR;
            ST_QT_Q:   nxt = (lc == CH_U) ? ST_QT_U : ST_ERROR;
            ST_QT_U:   nxt = (lc == CH_I) ? ST_QT_I : ST_ERROR;
            ST_QT_I:   nxt = (lc == CH_T) ? ST_QT_T : ST_ERROR;
            ST_QT_T:   nxt = is_sp ? ST_QT_SP : ST_ERROR;
            ST_QT_SP: begin
               if (is_sp) nxt = ST_QT_SP;
               else nxt = is_graph ? ST_QT_DAT : ST_ERROR;
            end
            ST_QT_DAT: nxt = is_graph ? ST_QT_DAT : ST_ERROR;
            ST_QT_OK:  nxt = is_sp ? ST_QT_OK : ST_ERROR;
            default:   nxt = ST_ERROR;
         endcase
      end
      step.nxt   = nxt;
      step.dat   = (nxt == ST_MV_DAT) || (nxt == ST_QT_DAT);
      step.fresh = (cur_state != ST_MV_DAT) && (cur_state != ST_QT_DAT);
   end

endmodule

`default_nettype wire
